@@ hw/rtl/vwap_position_in_range_defines.svh @@
// Assertion helpers for the VWAP position block.
`ifndef VWAP_POSITION_IN_RANGE_DEFINES_SVH
`define VWAP_POSITION_IN_RANGE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VPR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("vwap_position_in_range: assertion failed");

// Next-cycle implication, checked out of reset.
`define VPR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("vwap_position_in_range: assertion failed");

`endif

@@ hw/rtl/vpr_pkg.sv @@
package vpr_pkg;

    localparam int IN_BITS   = 24;  // width of every price and volume field
    localparam int WSUM_BITS = 64;  // price * volume accumulator
    localparam int VSUM_BITS = 40;  // volume accumulator
    localparam int VOL_HALF  = VSUM_BITS / 2;
    localparam int POS_BITS  = 18;

    localparam logic [POS_BITS-1:0] POS_MAX     = {1'b0, {(POS_BITS-1){1'b1}}};
    localparam logic [POS_BITS-1:0] POS_MIN_MAG = {1'b1, {(POS_BITS-1){1'b0}}};

    typedef struct packed {
        logic [IN_BITS-1:0] high_price;
        logic               high_ok;
        logic [IN_BITS-1:0] low_price;
        logic               low_ok;
        logic [IN_BITS-1:0] vwap_price;
        logic               vwap_ok;
        logic [IN_BITS-1:0] traded_volume;
        logic               volume_ok;
        logic               session_end;
    } in_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] position;
        logic                       position_ok;
    } out_t;

    typedef struct packed {
        logic       accumulate;
        logic       clear;
        logic       mul_en;
        logic [1:0] mul_phase;
        logic       prep;
        logic       div_step;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic calc_ok;
    } sts_t;

endpackage

@@ hw/rtl/vpr_datapath.sv @@
module vpr_datapath #(
    parameter int PRICE_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  vpr_pkg::in_t  s_data,
    input  vpr_pkg::cmd_t cmd,
    output vpr_pkg::sts_t sts,
    output vpr_pkg::out_t m_data
);

    localparam int WB       = vpr_pkg::WSUM_BITS;
    localparam int VB       = vpr_pkg::VSUM_BITS;
    localparam int HB       = vpr_pkg::VOL_HALF;
    localparam int PB       = vpr_pkg::POS_BITS;
    localparam int DIV_BITS = WB + FRAC_BITS;
    localparam int MUL_BITS = PRICE_BITS + HB;
    localparam int ACC_BITS = PRICE_BITS + vpr_pkg::IN_BITS;

    logic [PRICE_BITS-1:0] max_high_reg, max_high_next;
    logic                  high_seen_reg, high_seen_next;
    logic [PRICE_BITS-1:0] min_low_reg, min_low_next;
    logic                  low_seen_reg, low_seen_next;
    logic [WB-1:0]         wsum_reg, wsum_next;
    logic [VB-1:0]         vsum_reg, vsum_next;

    logic [WB-1:0]         lv_reg, lv_next;
    logic [WB-1:0]         den_reg, den_next;
    logic [DIV_BITS-1:0]   num_reg, num_next;
    logic [WB-1:0]         rem_reg, rem_next;
    logic [PB-1:0]         quo_reg, quo_next;
    logic                  ovf_reg, ovf_next;
    logic                  neg_reg, neg_next;
    vpr_pkg::out_t         out_reg, out_next;

    logic [PRICE_BITS-1:0] h, l, vw;
    logic [vpr_pkg::IN_BITS-1:0] v;
    logic [ACC_BITS-1:0]   prod_w;
    logic [PRICE_BITS-1:0] range_w;
    logic [PRICE_BITS-1:0] mul_a;
    logic [HB-1:0]         mul_b;
    logic [MUL_BITS-1:0]   mul_p;
    logic [WB-1:0]         addend;
    logic [WB:0]           trial;
    logic                  ge;
    logic                  calc_ok;
    logic                  big;

    assign h  = s_data.high_price[PRICE_BITS-1:0];
    assign l  = s_data.low_price[PRICE_BITS-1:0];
    assign vw = s_data.vwap_price[PRICE_BITS-1:0];
    assign v  = s_data.traded_volume;

    assign prod_w  = ACC_BITS'(vw) * ACC_BITS'(v);
    assign range_w = max_high_reg - min_low_reg;

    // shared multiplier: L*vol then (H-L)*vol, low half of vol first
    assign mul_a  = cmd.mul_phase[1] ? range_w : min_low_reg;
    assign mul_b  = cmd.mul_phase[0] ? vsum_reg[VB-1:HB] : vsum_reg[HB-1:0];
    assign mul_p  = MUL_BITS'(mul_a) * MUL_BITS'(mul_b);
    assign addend = WB'(mul_p) << HB;

    assign trial = {rem_reg, num_reg[DIV_BITS-1]};
    assign ge    = trial >= {1'b0, den_reg};

    assign calc_ok = high_seen_reg && low_seen_reg && (max_high_reg > min_low_reg)
                     && (vsum_reg != '0);
    assign sts.calc_ok = calc_ok;

    always_comb begin
        max_high_next  = max_high_reg;
        high_seen_next = high_seen_reg;
        min_low_next   = min_low_reg;
        low_seen_next  = low_seen_reg;
        wsum_next      = wsum_reg;
        vsum_next      = vsum_reg;
        lv_next        = lv_reg;
        den_next       = den_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        out_next       = out_reg;
        big            = 1'b0;

        if (cmd.accumulate) begin
            if (s_data.high_ok && (!high_seen_reg || h > max_high_reg)) begin
                max_high_next  = h;
                high_seen_next = 1'b1;
            end
            if (s_data.low_ok && (!low_seen_reg || l < min_low_reg)) begin
                min_low_next  = l;
                low_seen_next = 1'b1;
            end
            if (s_data.vwap_ok && s_data.volume_ok && v != '0) begin
                wsum_next = wsum_reg + WB'(prod_w);
                vsum_next = vsum_reg + VB'(v);
            end
        end

        if (cmd.mul_en) begin
            unique case (cmd.mul_phase)
                2'd0: lv_next = WB'(mul_p);
                2'd1: lv_next = lv_reg + addend;
                2'd2: den_next = WB'(mul_p);
                default: den_next = den_reg + addend;
            endcase
        end

        if (cmd.prep) begin
            neg_next = wsum_reg < lv_reg;
            num_next = {(wsum_reg < lv_reg) ? (lv_reg - wsum_reg) : (wsum_reg - lv_reg),
                        {FRAC_BITS{1'b0}}};
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
        end

        // restoring divide, one numerator bit per step
        if (cmd.div_step) begin
            rem_next = ge ? WB'(trial - {1'b0, den_reg}) : trial[WB-1:0];
            num_next = num_reg << 1;
            quo_next = {quo_reg[PB-2:0], ge};
            ovf_next = ovf_reg | quo_reg[PB-1];
        end

        if (cmd.load_out) begin
            out_next.position_ok = calc_ok;
            if (!calc_ok) begin
                out_next.position = '0;
            end else if (neg_reg) begin
                big = ovf_reg || quo_reg > vpr_pkg::POS_MIN_MAG;
                out_next.position = big ? vpr_pkg::POS_MIN_MAG : PB'('0 - quo_reg);
            end else begin
                big = ovf_reg || quo_reg > vpr_pkg::POS_MAX;
                out_next.position = big ? vpr_pkg::POS_MAX : quo_reg;
            end
        end

        if (cmd.clear) begin
            max_high_next  = '0;
            high_seen_next = 1'b0;
            min_low_next   = '1;
            low_seen_next  = 1'b0;
            wsum_next      = '0;
            vsum_next      = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_high_reg  <= '0;
            high_seen_reg <= 1'b0;
            min_low_reg   <= '1;
            low_seen_reg  <= 1'b0;
            wsum_reg      <= '0;
            vsum_reg      <= '0;
        end else begin
            max_high_reg  <= max_high_next;
            high_seen_reg <= high_seen_next;
            min_low_reg   <= min_low_next;
            low_seen_reg  <= low_seen_next;
            wsum_reg      <= wsum_next;
            vsum_reg      <= vsum_next;
        end
    end

    always_ff @(posedge aclk) begin
        lv_reg  <= lv_next;
        den_reg <= den_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

@@ hw/rtl/vpr_ctrl.sv @@
module vpr_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          session_end,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    input  vpr_pkg::sts_t sts,
    output vpr_pkg::cmd_t cmd
);

    localparam int DIV_STEPS = vpr_pkg::WSUM_BITS + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cmd.mul_phase = phase_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accumulate = 1'b1;
                    if (session_end) begin
                        state_next = ST_MUL;
                        phase_next = 2'd0;
                    end
                end
            end
            ST_MUL: begin
                // nothing to divide when the range or volume is empty
                if (!sts.calc_ok) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.mul_en = 1'b1;
                    phase_next = phase_reg + 2'd1;
                    if (phase_reg == 2'd3) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    cmd.clear    = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = cmd.load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ hw/rtl/vwap_position_in_range.sv @@
// Position of the session VWAP inside the session high-low range, signed Q1.16.
// Intervals are taken one per cycle while the block accumulates. The request
// flagged session_end closes the session: the block then stops taking requests
// while a shared PRICE_BITS x 20 multiplier forms L*vol and vol*(H-L) in four
// passes and a one-bit-per-cycle restoring divider produces the quotient. A
// session with no usable range or volume skips that work and holds off requests
// only until its zero result is loaded. The result sits in an output register,
// so the next session can start while it waits to be taken.
`include "vwap_position_in_range_defines.svh"

module vwap_position_in_range #(
    parameter int PRICE_BITS = 24,
    parameter int FRAC_BITS  = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  vpr_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output vpr_pkg::out_t m_data
);

    vpr_pkg::cmd_t cmd;
    vpr_pkg::sts_t sts;
    logic          end_taken;
    logic          nan_out;

    vpr_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .session_end(s_data.session_end),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    vpr_datapath #(
        .PRICE_BITS(PRICE_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_data (m_data)
    );

    assign end_taken = s_valid && s_ready && s_data.session_end;
    assign nan_out   = m_valid && !m_data.position_ok;

    `VPR_ASSERT_NEXT(a_load_gives_valid, aclk, aresetn, cmd.load_out, m_valid)
    `VPR_ASSERT_NEXT(a_end_stalls_input, aclk, aresetn, end_taken, !s_ready)
    `VPR_ASSERT_IMPL(a_nan_reads_zero, aclk, aresetn, nan_out, m_data.position == '0)

endmodule
